>>> src/nds_pkg.sv
// nds_pkg: shared types and constants of the note duration scheduler
// holds the track slot, request and message structs and the message codes
// no dependencies; used by nds_cell, nds_head and the top level
package nds_pkg;

   // message kind codes
   localparam logic KIND_NOTE_ON  = 1'b0;
   localparam logic KIND_NOTE_OFF = 1'b1;

   // request action codes
   localparam logic ACT_PLAY = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // at most this many note-offs per tick
   localparam int MAX_RESULTS = 8;
   localparam int RELEASE_W   = $clog2(MAX_RESULTS + 1);

   // one track slot as it travels along the ring
   typedef struct packed {
      logic        active;
      logic [15:0] deadline;
      logic [6:0]  note;
      logic [3:0]  channel;
   } slot_type;

   // captured request beat, with the deadline already formed
   typedef struct packed {
      logic        action;
      logic [15:0] now_ms;
      logic [2:0]  track;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [15:0] deadline;
      logic        track_ok;
   } req_type;

   // one outgoing message
   typedef struct packed {
      logic       kind;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [2:0] track;
   } msg_type;

   // per-cycle event from the head of the ring
   typedef struct packed {
      logic    valid;
      msg_type msg;
   } event_type;

endpackage

>>> src/nds_cell.sv
// nds_cell: one storage cell of the slot ring
// holds one track slot and loads its neighbor's slot on every shift
// depends on nds_pkg for slot_type
module nds_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  nds_pkg::slot_type slot_in,
   output nds_pkg::slot_type slot_out
);

   logic              active_ff;
   nds_pkg::slot_type payload_ff;

   // active flag is control state and clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (shift_en) begin
         active_ff <= slot_in.active;
      end
   end

   // deadline, note and channel are payload
   always_ff @(posedge clock) begin
      if (shift_en) begin
         payload_ff <= slot_in;
      end
   end

   always_comb begin
      slot_out        = payload_ff;
      slot_out.active = active_ff;
   end

endmodule

>>> src/nds_head.sv
// nds_head: update logic at the head of the slot ring
// decides expiry or replacement for the slot passing by and forms its message
// depends on nds_pkg for slot, request and event types
module nds_head #(
   parameter int TRACK_W = 3
) (
   input  nds_pkg::slot_type  head_slot,
   input  logic [TRACK_W-1:0] step,
   input  nds_pkg::req_type   req,
   input  logic               release_full,
   output nds_pkg::slot_type  slot_next,
   output nds_pkg::event_type head_event
);

   logic [15:0] diff;
   logic        expired;
   logic        match;

   // signed 16-bit distance to the deadline
   assign diff    = req.now_ms - head_slot.deadline;
   assign expired = ~diff[15];
   assign match   = req.track_ok && (6'(req.track) == 6'(step));

   always_comb begin
      slot_next                 = head_slot;
      head_event.valid          = 1'b0;
      head_event.msg.kind       = nds_pkg::KIND_NOTE_OFF;
      head_event.msg.channel    = head_slot.channel;
      head_event.msg.note       = head_slot.note;
      head_event.msg.velocity   = 7'd0;
      head_event.msg.track      = 3'(step);
      if (req.action == nds_pkg::ACT_TICK) begin
         // release an expired note while the per-tick budget lasts
         if (head_slot.active && expired && !release_full) begin
            head_event.valid = 1'b1;
            slot_next.active = 1'b0;
         end
      end else if (match) begin
         // release the old note, then arm the slot with the new one
         head_event.valid   = head_slot.active;
         slot_next.active   = 1'b1;
         slot_next.deadline = req.deadline;
         slot_next.note     = req.note;
         slot_next.channel  = req.channel;
      end
   end

endmodule

>>> src/note_duration_scheduler_unit.sv
// note_duration_scheduler_unit: top level of the note duration scheduler
// a ring of nds_cell slots rotated past one nds_head update unit
// depends on nds_pkg, nds_cell and nds_head
//
// Usage:
//   A request beat (req_*) is taken on a rising edge with start high and busy
//   low. req_action play stores a note on track req_track_index and gives an
//   optional note-off for the old note followed by a note-on; tick gives a
//   note-off for every expired slot in track order, at most eight per tick.
//   Messages leave on the rsp_* ports, each for one cycle under rsp_valid;
//   rsp_last_result marks the final message of a request. The receiver has
//   no way to hold messages off, and none is needed.
//   During busy the slot ring rotates once past the head unit, one track
//   per cycle, then the note-on is inserted and the last message is handed
//   over. A message is held until the next message is formed and leaves in
//   the cycle after that; the last one is on the ports in the first cycle
//   after busy falls. Messages of one request can come in consecutive
//   cycles or with gaps. A new beat is taken only once busy is low again,
//   so the block does not take a new request before it is through with the
//   last one.
//   Synchronous reset clears all active flags and returns to idle; no slot
//   contents need clearing.
module note_duration_scheduler_unit #(
   parameter int TRACK_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_now_ms,
   input  logic [2:0]  req_track_index,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note_number,
   input  logic [6:0]  req_velocity,
   input  logic [14:0] req_length_ms,
   output logic        rsp_valid,
   output logic        rsp_message_kind,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_out_note,
   output logic [6:0]  rsp_out_velocity,
   output logic [2:0]  rsp_out_track,
   output logic        rsp_last_result
);

   localparam int TRACK_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
   localparam logic [TRACK_W-1:0] LAST_STEP = TRACK_W'(TRACK_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_INJECT = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [TRACK_W-1:0]          step_ff, step_in;
   logic [nds_pkg::RELEASE_W-1:0] release_ff, release_in;
   nds_pkg::req_type            req_ff, req_in;
   logic                        pend_valid_ff, pend_valid_in;
   nds_pkg::msg_type            pend_ff, pend_in;
   logic                        out_valid_ff, out_valid_in;
   nds_pkg::msg_type            out_msg_ff, out_msg_in;
   logic                        out_last_ff, out_last_in;

   logic                        shift_en;
   nds_pkg::slot_type           cell_q [TRACK_COUNT];
   nds_pkg::slot_type           head_next;
   nds_pkg::event_type          head_event;
   nds_pkg::event_type          cur_event;
   logic                        release_full;

   // ring of slot cells, cell 0 is the head, the updated head reenters at the tail
   assign shift_en = (state_ff == ST_SCAN);

   for (genvar i = 0; i < TRACK_COUNT; i++) begin : g_cell
      nds_pkg::slot_type cell_in;
      if (i == TRACK_COUNT - 1) begin : g_tail
         assign cell_in = head_next;
      end else begin : g_mid
         assign cell_in = cell_q[i + 1];
      end
      nds_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  (cell_in),
         .slot_out (cell_q[i])
      );
   end

   // head update unit
   assign release_full = (release_ff == nds_pkg::RELEASE_W'(nds_pkg::MAX_RESULTS));

   nds_head #(
      .TRACK_W (TRACK_W)
   ) u_head (
      .head_slot    (cell_q[0]),
      .step         (step_ff),
      .req          (req_ff),
      .release_full (release_full),
      .slot_next    (head_next),
      .head_event   (head_event)
   );

   // event source of this cycle: head during the scan, note-on afterwards
   always_comb begin
      cur_event              = head_event;
      cur_event.valid        = 1'b0;
      if (state_ff == ST_SCAN) begin
         cur_event.valid = head_event.valid;
      end else if (state_ff == ST_INJECT) begin
         cur_event.valid        = (req_ff.action == nds_pkg::ACT_PLAY) && req_ff.track_ok;
         cur_event.msg.kind     = nds_pkg::KIND_NOTE_ON;
         cur_event.msg.channel  = req_ff.channel;
         cur_event.msg.note     = req_ff.note;
         cur_event.msg.velocity = req_ff.velocity;
         cur_event.msg.track    = req_ff.track;
      end
   end

   // sequencer, pending message and output beat
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      release_in    = release_ff;
      req_in        = req_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = 1'b0;
      out_msg_in    = pend_ff;
      out_last_in   = 1'b0;

      // a new event pushes the held message out as a non-final beat
      if (cur_event.valid) begin
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_in       = cur_event.msg;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in.action   = req_action;
               req_in.now_ms   = req_now_ms;
               req_in.track    = req_track_index;
               req_in.channel  = req_channel;
               req_in.note     = req_note_number;
               req_in.velocity = req_velocity;
               req_in.deadline = req_now_ms + {1'b0, req_length_ms};
               req_in.track_ok = (32'(req_track_index) < 32'(TRACK_COUNT));
               step_in         = '0;
               release_in      = '0;
               pend_valid_in   = 1'b0;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (head_event.valid && (req_ff.action == nds_pkg::ACT_TICK)) begin
               release_in = release_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_INJECT;
            end
         end
         ST_INJECT: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            // the held message is the last one of this request
            out_valid_in  = pend_valid_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      release_ff  <= release_in;
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      out_msg_ff  <= out_msg_in;
      out_last_ff <= out_last_in;
   end

   // ports
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_message_kind = out_msg_ff.kind;
   assign rsp_out_channel  = out_msg_ff.channel;
   assign rsp_out_note     = out_msg_ff.note;
   assign rsp_out_velocity = out_msg_ff.velocity;
   assign rsp_out_track    = out_msg_ff.track;
   assign rsp_last_result  = out_last_ff;

endmodule

>>> bench/tb_note_duration_scheduler_unit.sv
// tb_note_duration_scheduler_unit: self-checking bench for the note duration scheduler
// a directed table and phased random beats, checked against a per-track slot predictor
// depends on nds_pkg and note_duration_scheduler_unit
module tb_note_duration_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_TRACKS    = 8;
   localparam int SETTLE_CYC  = N_TRACKS + 4;
   localparam int BEATS_PHASE = 75;

   // one request beat as driven on the req_ ports
   typedef struct packed {
      logic        action;
      logic [15:0] now_ms;
      logic [2:0]  track;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [14:0] length_ms;
   } note_req_type;

   // one note message with its last flag
   typedef struct packed {
      nds_pkg::msg_type msg;
      logic             last;
   } note_msg_type;

   // how a directed row is checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_SINGLE} row_check_type;

   typedef struct {
      note_req_type  req;
      row_check_type check;
      note_msg_type  typed;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = nds_pkg::ACT_TICK;
   logic [15:0] req_now_ms = '0;
   logic [2:0]  req_track_index = '0;
   logic [3:0]  req_channel = '0;
   logic [6:0]  req_note_number = '0;
   logic [6:0]  req_velocity = '0;
   logic [14:0] req_length_ms = '0;
   logic        rsp_valid;
   logic        rsp_message_kind;
   logic [3:0]  rsp_out_channel;
   logic [6:0]  rsp_out_note;
   logic [6:0]  rsp_out_velocity;
   logic [2:0]  rsp_out_track;
   logic        rsp_last_result;

   // predictor copy of the track slots
   logic        track_on   [N_TRACKS];
   logic [15:0] track_due  [N_TRACKS];
   logic [6:0]  track_note [N_TRACKS];
   logic [3:0]  track_chan [N_TRACKS];

   note_msg_type step_msgs [nds_pkg::MAX_RESULTS];
   note_msg_type msgs_due [$];
   dir_row_type  directed_rows [$];

   int error_count  = 0;
   int msgs_checked = 0;
   int plays_sent   = 0;
   int ticks_sent   = 0;

   // sender idle percentage per phase; the receiver cannot stall, so its phase
   // runs without idling and the combined phase keeps only the sender part
   int idle_pct [4] = '{0, 47, 0, 26};

   note_duration_scheduler_unit #(.TRACK_COUNT(N_TRACKS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_now_ms       (req_now_ms),
      .req_track_index  (req_track_index),
      .req_channel      (req_channel),
      .req_note_number  (req_note_number),
      .req_velocity     (req_velocity),
      .req_length_ms    (req_length_ms),
      .rsp_valid        (rsp_valid),
      .rsp_message_kind (rsp_message_kind),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_out_track    (rsp_out_track),
      .rsp_last_result  (rsp_last_result)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic log_mismatch(input string what, input int want, input int seen);
      $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, seen);
      error_count++;
   endtask

   function automatic note_msg_type make_msg(input logic kind, input logic [3:0] chan,
                                             input logic [6:0] note, input logic [6:0] vel,
                                             input logic [2:0] trk, input logic last);
      note_msg_type m;
      m.msg.kind     = kind;
      m.msg.channel  = chan;
      m.msg.note     = note;
      m.msg.velocity = vel;
      m.msg.track    = trk;
      m.last         = last;
      return m;
   endfunction

   // slot update for one beat; fills step_msgs and returns the message count
   function automatic int advance_tracks(input note_req_type r);
      int          n;
      logic [15:0] lag;
      n = 0;
      if (r.action == nds_pkg::ACT_PLAY) begin
         if (int'(r.track) >= N_TRACKS)
            return 0;
         // release the note still sounding on this track
         if (track_on[r.track]) begin
            step_msgs[n] = make_msg(nds_pkg::KIND_NOTE_OFF, track_chan[r.track],
                                    track_note[r.track], 7'd0, r.track, 1'b0);
            n++;
         end
         track_due[r.track]  = r.now_ms + 16'(r.length_ms);
         track_on[r.track]   = 1'b1;
         track_chan[r.track] = r.channel;
         track_note[r.track] = r.note;
         step_msgs[n] = make_msg(nds_pkg::KIND_NOTE_ON, r.channel, r.note, r.velocity,
                                 r.track, 1'b0);
         n++;
      end else begin
         // expiry scan in track order, signed 16-bit distance
         for (int t = 0; t < N_TRACKS && n < nds_pkg::MAX_RESULTS; t++) begin
            if (track_on[t]) begin
               lag = r.now_ms - track_due[t];
               if (!lag[15]) begin
                  step_msgs[n] = make_msg(nds_pkg::KIND_NOTE_OFF, track_chan[t],
                                          track_note[t], 7'd0, 3'(t), 1'b0);
                  n++;
                  track_on[t] = 1'b0;
               end
            end
         end
      end
      if (n > 0)
         step_msgs[n - 1].last = 1'b1;
      return n;
   endfunction

   // drive one beat, wait for it to be taken, then queue what it should give
   task automatic send_beat(input note_req_type r, input row_check_type chk,
                            input note_msg_type typed);
      int n;
      start           <= 1'b1;
      req_action      <= r.action;
      req_now_ms      <= r.now_ms;
      req_track_index <= r.track;
      req_channel     <= r.channel;
      req_note_number <= r.note;
      req_velocity    <= r.velocity;
      req_length_ms   <= r.length_ms;
      do @(posedge clock); while (busy);
      n = advance_tracks(r);
      if (r.action == nds_pkg::ACT_PLAY)
         plays_sent++;
      else
         ticks_sent++;
      case (chk)
         CHK_MODEL: begin
            for (int i = 0; i < n; i++)
               msgs_due.push_back(step_msgs[i]);
         end
         CHK_SINGLE: begin
            msgs_due.push_back(typed);
         end
         default: begin
         end
      endcase
   endtask

   // hold off until every expected message is out, then let the block settle
   task automatic drain_and_settle();
      start <= 1'b0;
      while (msgs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic dir_row_type stim_row(input logic act, input int now, input int trk,
                                            input int ch, input int note, input int vel,
                                            input int len,
                                            input row_check_type chk = CHK_MODEL,
                                            input note_msg_type typed = '0);
      dir_row_type row;
      row.req.action    = act;
      row.req.now_ms    = 16'(now);
      row.req.track     = 3'(trk);
      row.req.channel   = 4'(ch);
      row.req.note      = 7'(note);
      row.req.velocity  = 7'(vel);
      row.req.length_ms = 15'(len);
      row.check         = chk;
      row.typed         = typed;
      return row;
   endfunction

   // result monitor: each message beat against the oldest expectation
   always @(posedge clock) begin
      note_msg_type want;
      if (!reset && rsp_valid) begin
         if (msgs_due.size() == 0) begin
            log_mismatch("messages pending", 0, 1);
         end else begin
            want = msgs_due.pop_front();
            msgs_checked++;
            if (rsp_message_kind !== want.msg.kind)
               log_mismatch("message kind", want.msg.kind, rsp_message_kind);
            if (rsp_out_channel !== want.msg.channel)
               log_mismatch("channel", want.msg.channel, rsp_out_channel);
            if (rsp_out_note !== want.msg.note)
               log_mismatch("note", want.msg.note, rsp_out_note);
            if (rsp_out_velocity !== want.msg.velocity)
               log_mismatch("velocity", want.msg.velocity, rsp_out_velocity);
            if (rsp_out_track !== want.msg.track)
               log_mismatch("track", want.msg.track, rsp_out_track);
            if (rsp_last_result !== want.last)
               log_mismatch("last flag", want.last, rsp_last_result);
         end
      end
   end

   // stimulus
   initial begin
      note_req_type r;
      logic [15:0]  ms_clock;

      foreach (track_on[t])
         track_on[t] = 1'b0;
      ms_clock = 16'($urandom);

      // directed table
      // tick right after reset finds nothing
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, CHK_SILENT));
      // all-zero play and all-ones play with the deadline wrapping
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 0, 0, 0, 0, 0, 0, CHK_SINGLE,
                                       make_msg(nds_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd0,
                                                3'd0, 1'b1)));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 65535, 7, 15, 127, 127, 32767,
                                       CHK_SINGLE,
                                       make_msg(nds_pkg::KIND_NOTE_ON, 4'd15, 7'd127,
                                                7'd127, 3'd7, 1'b1)));
      // zero length expires on the next tick, the far deadline does not
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, CHK_SINGLE,
                                       make_msg(nds_pkg::KIND_NOTE_OFF, 4'd0, 7'd0, 7'd0,
                                                3'd0, 1'b1)));
      // replay on an active track: note-off for the old note first
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 1000, 3, 5, 60, 100, 100));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 1010, 3, 6, 61, 90, 200));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 1100, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 1210, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 32766, 0, 0, 0, 0, 0));
      // every track busy, then one tick releases all of them
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 0, 8, 7, 1, 0));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 1, 9, 17, 20, 1));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 2, 10, 27, 40, 255));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 3, 11, 37, 60, 4096));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 4, 12, 47, 80, 8191));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 5, 13, 57, 100, 16384));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 6, 14, 67, 120, 30000));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 2000, 7, 15, 127, 127, 32767));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 34767, 0, 0, 0, 0, 0));
      // half-range edge of the signed distance
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 100, 2, 9, 42, 1, 32767));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 99, 0, 0, 0, 0, 0));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 65634, 0, 0, 0, 0, 0));
      // quick replace then release
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 500, 4, 3, 64, 127, 0));
      directed_rows.push_back(stim_row(nds_pkg::ACT_PLAY, 500, 4, 12, 65, 64, 5));
      directed_rows.push_back(stim_row(nds_pkg::ACT_TICK, 505, 0, 0, 0, 0, 0));

      // reset
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].req, directed_rows[i].check, directed_rows[i].typed);
      drain_and_settle();

      // random phases: a running millisecond clock, some noise on now_ms
      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < BEATS_PHASE; k++) begin
            if (idle_pct[ph] != 0 && $urandom_range(99) < idle_pct[ph]) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            if ($urandom_range(99) < 90)
               ms_clock += 16'($urandom_range(0, 400));
            else
               ms_clock += 16'($urandom_range(0, 40000));
            r.action    = ($urandom_range(99) < 45) ? nds_pkg::ACT_TICK : nds_pkg::ACT_PLAY;
            r.now_ms    = ($urandom_range(99) < 5) ? 16'($urandom) : ms_clock;
            r.track     = 3'($urandom_range(N_TRACKS - 1));
            r.channel   = 4'($urandom);
            r.note      = 7'($urandom);
            r.velocity  = 7'($urandom);
            r.length_ms = ($urandom_range(99) < 80) ? 15'($urandom_range(0, 1500))
                                                    : 15'($urandom);
            send_beat(r, CHK_MODEL, '0);
         end
         drain_and_settle();
      end

      if (msgs_due.size() != 0)
         log_mismatch("messages left over", 0, msgs_due.size());
      $display("covered %0d play beats and %0d tick beats over four idle phases",
               plays_sent, ticks_sent);
      $display("compared %0d note messages, %0d mismatches", msgs_checked, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
